/* hw/rtl/svie_pkg.sv */
`default_nettype none
package svie_pkg;

  typedef enum logic [5:0] {
    OP_NOP     = 6'd0,
    OP_NEG     = 6'd1,
    OP_ADD     = 6'd2,
    OP_SUB     = 6'd3,
    OP_MUL     = 6'd4,
    OP_DIV     = 6'd5,
    OP_MOD     = 6'd6,
    OP_EQUAL   = 6'd7,
    OP_NOTEQ   = 6'd8,
    OP_LESS    = 6'd9,
    OP_LEQ     = 6'd10,
    OP_GREATER = 6'd11,
    OP_GEQ     = 6'd12,
    OP_SET     = 6'd13,
    OP_LOAD    = 6'd14,
    OP_LOADR   = 6'd15,
    OP_SAVE    = 6'd16,
    OP_SAVER   = 6'd17,
    OP_JUMP    = 6'd18,
    OP_JUMPF   = 6'd19,
    OP_PUSH    = 6'd20,
    OP_POP     = 6'd21,
    OP_SWAP    = 6'd22,
    OP_READ    = 6'd23,
    OP_WRITE   = 6'd24,
    OP_READCH  = 6'd25,
    OP_WRITECH = 6'd26,
    OP_HALT    = 6'd27,
    OP_CALL    = 6'd28,
    OP_RETURN  = 6'd29,
    OP_ALLOC   = 6'd30,
    OP_FREE    = 6'd31,
    OP_TOPST   = 6'd32
  } op_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_DIV0    = 3'd1;
  localparam logic [2:0] ERR_ADDR    = 3'd2;
  localparam logic [2:0] ERR_OVF     = 3'd3;
  localparam logic [2:0] ERR_EMPTY   = 3'd4;
  localparam logic [2:0] ERR_LABEL   = 3'd5;
  localparam logic [2:0] ERR_READ    = 3'd6;
  localparam logic [2:0] ERR_ILLEGAL = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_DIV,
    S_CALL2,
    S_RET_BASE,
    S_RET_PC,
    S_FILL,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_EXEC,
    CMD_LOAD,
    CMD_DIV,
    CMD_CALL2,
    CMD_RET_BASE,
    CMD_RET_PC,
    CMD_FILL,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic pre_halt;
    logic to_load;
    logic to_div;
    logic to_call2;
    logic to_ret;
    logic to_fill;
    logic div_last;
    logic ret_more;
    logic fill_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* hw/rtl/svie_ram.sv */
`default_nettype none
module svie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/svie_dp.sv */
`default_nettype none
module svie_dp #(
  parameter int STACK_DEPTH   = 1024,
  parameter int PROGRAM_DEPTH = 65536
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [16:0]      cfg_wr_data,
  input  wire logic [5:0]       mode,
  input  wire logic [31:0]      operand,
  input  wire logic [31:0]      input_value,
  input  wire logic             read_valid,
  input  svie_pkg::cmd_t        cmd,
  output svie_pkg::status_t     status,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output logic      [16:0]      next_pc,
  output logic      [1:0]       out_kind,
  output logic      [31:0]      out_value,
  output logic      [2:0]       error_code,
  output logic                  halted
);
  import svie_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
  localparam logic [16:0] PLEN_MAX =
    (PROGRAM_DEPTH > 131071) ? 17'h1FFFF : 17'(PROGRAM_DEPTH);
  localparam logic [16:0] PLEN_RST =
    (PROGRAM_DEPTH < 65536) ? 17'(PROGRAM_DEPTH) : 17'd65536;

  // machine state
  logic [31:0]   acc, acc_next;
  logic [31:0]   sr, sr_next;
  logic [31:0]   base, base_next;
  logic [16:0]   pc, pc_next;
  logic          halt_flag, halt_next;
  logic [CW-1:0] count, count_next;
  logic [16:0]   plen;

  // latched item and pending result
  op_t         op;
  logic [31:0] opnd;
  logic [31:0] inval;
  logic        rvalid;
  logic [1:0]  res_kind, res_kind_next;
  logic [31:0] res_val, res_val_next;
  logic [2:0]  res_err, res_err_next;

  // divider and fill sequencing
  logic [31:0]   dq, dq_next;
  logic [31:0]   drem, drem_next;
  logic [31:0]   dmb, dmb_next;
  logic [5:0]    dcnt, dcnt_next;
  logic          dneg_q, dneg_q_next;
  logic          dneg_r, dneg_r_next;
  logic [CW-1:0] fill_left, fill_next;

  // stack store port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic [16:0]   pc_adv;
  logic          has_imm;
  logic [31:0]   ld_addr, sv_addr;
  logic [CW-1:0] cnt_m1, ret_cnt, ret_m1, room;
  logic [33:0]   dtrial;
  logic          full;
  logic          halt_final;

  // branch requests from the execute step
  logic          st_load, st_div, st_call2, st_ret, st_fill;

  svie_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign has_imm = (op == OP_SET) || (op == OP_JUMP) || (op == OP_JUMPF) ||
                   (op == OP_CALL) || (op == OP_ALLOC) || (op == OP_FREE);
  assign pc_adv  = pc + (has_imm ? 17'd2 : 17'd1);
  assign ld_addr = acc + ((op == OP_LOADR) ? base : 32'd0);
  assign sv_addr = sr + ((op == OP_SAVER) ? base : 32'd0);
  assign cnt_m1  = count - 1'b1;
  assign ret_cnt = (32'(count) > base) ? base[CW-1:0] : count;
  assign ret_m1  = ret_cnt - 1'b1;
  assign room    = CNT_FULL - count;
  assign full    = (count == CNT_FULL);
  assign dtrial  = {1'b0, drem, dq[31]} - {2'b00, dmb};
  assign halt_final = halt_flag || (pc >= plen);

  assign status.pre_halt  = halt_flag || (pc >= plen);
  assign status.to_load   = st_load;
  assign status.to_div    = st_div;
  assign status.to_call2  = st_call2;
  assign status.to_ret    = st_ret;
  assign status.to_fill   = st_fill;
  assign status.div_last  = dcnt[5];
  assign status.ret_more  = (count != '0);
  assign status.fill_last = (fill_left == CW'(1));
  assign status.out_free  = !out_valid || !out_stall;

  always_comb begin
    acc_next      = acc;
    sr_next       = sr;
    base_next     = base;
    pc_next       = pc;
    halt_next     = halt_flag;
    count_next    = count;
    res_kind_next = res_kind;
    res_val_next  = res_val;
    res_err_next  = res_err;
    dq_next       = dq;
    drem_next     = drem;
    dmb_next      = dmb;
    dcnt_next     = dcnt;
    dneg_q_next   = dneg_q;
    dneg_r_next   = dneg_r;
    fill_next     = fill_left;
    ram_we        = 1'b0;
    ram_waddr     = count[AW-1:0];
    ram_wdata     = 32'd0;
    ram_re        = 1'b0;
    ram_raddr     = cnt_m1[AW-1:0];
    st_load       = 1'b0;
    st_div        = 1'b0;
    st_call2      = 1'b0;
    st_ret        = 1'b0;
    st_fill       = 1'b0;

    case (cmd)
      CMD_LATCH: begin
        res_kind_next = KIND_NONE;
        res_val_next  = 32'd0;
        res_err_next  = ERR_NONE;
      end
      CMD_EXEC: begin
        if (halt_final) begin
          halt_next = 1'b1;
        end else begin
          pc_next = pc_adv;
          case (op)
            OP_NOP: ;
            OP_NEG:     acc_next = 32'd0 - acc;
            OP_ADD:     acc_next = acc + sr;
            OP_SUB:     acc_next = acc - sr;
            OP_MUL:     acc_next = acc * sr;
            OP_DIV, OP_MOD: begin
              if (sr == 32'd0) begin
                res_err_next = ERR_DIV0;
              end else begin
                dq_next       = acc[31] ? 32'd0 - acc : acc;
                dmb_next      = sr[31] ? 32'd0 - sr : sr;
                drem_next     = 32'd0;
                dcnt_next     = 6'd0;
                dneg_q_next   = acc[31] ^ sr[31];
                dneg_r_next   = acc[31];
                st_div        = 1'b1;
              end
            end
            OP_EQUAL:   acc_next = {31'd0, acc == sr};
            OP_NOTEQ:   acc_next = {31'd0, acc != sr};
            OP_LESS:    acc_next = {31'd0, $signed(acc) <  $signed(sr)};
            OP_LEQ:     acc_next = {31'd0, $signed(acc) <= $signed(sr)};
            OP_GREATER: acc_next = {31'd0, $signed(acc) >  $signed(sr)};
            OP_GEQ:     acc_next = {31'd0, $signed(acc) >= $signed(sr)};
            OP_SET:     acc_next = opnd;
            OP_LOAD, OP_LOADR: begin
              if (ld_addr < 32'(count)) begin
                ram_re    = 1'b1;
                ram_raddr = ld_addr[AW-1:0];
                st_load   = 1'b1;
              end else begin
                res_err_next = ERR_ADDR;
              end
            end
            OP_SAVE, OP_SAVER: begin
              if (sv_addr < 32'(count)) begin
                ram_we    = 1'b1;
                ram_waddr = sv_addr[AW-1:0];
                ram_wdata = acc;
              end else begin
                res_err_next = ERR_ADDR;
              end
            end
            OP_JUMP: begin
              if (opnd >= 32'(plen)) res_err_next = ERR_LABEL;
              else pc_next = opnd[16:0];
            end
            OP_JUMPF: begin
              if (acc == 32'd0) begin
                if (opnd >= 32'(plen)) res_err_next = ERR_LABEL;
                else pc_next = opnd[16:0];
              end
            end
            OP_PUSH: begin
              if (full) begin
                res_err_next = ERR_OVF;
              end else begin
                ram_we     = 1'b1;
                ram_wdata  = acc;
                count_next = count + 1'b1;
              end
            end
            OP_POP: begin
              if (count == '0) begin
                res_err_next = ERR_EMPTY;
              end else begin
                ram_re     = 1'b1;
                count_next = cnt_m1;
                st_load    = 1'b1;
              end
            end
            OP_SWAP: begin
              acc_next = sr;
              sr_next  = acc;
            end
            OP_READ: begin
              if (rvalid) acc_next = inval;
              else res_err_next = ERR_READ;
            end
            OP_WRITE: begin
              res_kind_next = KIND_INT;
              res_val_next  = acc;
            end
            OP_READCH:  acc_next = inval;
            OP_WRITECH: begin
              res_kind_next = KIND_CHAR;
              res_val_next  = acc;
            end
            OP_HALT:    halt_next = 1'b1;
            OP_CALL: begin
              if (full) begin
                res_err_next = ERR_OVF;
              end else begin
                ram_we     = 1'b1;
                ram_wdata  = {15'd0, pc_adv};
                count_next = count + 1'b1;
                st_call2   = 1'b1;
              end
            end
            OP_RETURN: begin
              if (base[31]) begin
                count_next   = '0;
                res_err_next = ERR_EMPTY;
              end else if (ret_cnt != '0) begin
                ram_re     = 1'b1;
                ram_raddr  = ret_m1[AW-1:0];
                count_next = ret_m1;
                st_ret     = 1'b1;
              end else begin
                count_next = ret_cnt;
              end
            end
            OP_ALLOC: begin
              if (!opnd[31] && opnd != 32'd0) begin
                if (opnd > 32'(room)) begin
                  fill_next    = room;
                  res_err_next = ERR_OVF;
                end else begin
                  fill_next = opnd[CW-1:0];
                end
                st_fill = (fill_next != '0);
              end
            end
            OP_FREE: begin
              if (!opnd[31] && opnd != 32'd0) begin
                if (opnd > 32'(count)) begin
                  count_next   = '0;
                  res_err_next = ERR_EMPTY;
                end else begin
                  count_next = count - opnd[CW-1:0];
                end
              end
            end
            OP_TOPST:   acc_next = 32'(count);
            default: begin
              res_err_next = ERR_ILLEGAL;
              halt_next    = 1'b1;
            end
          endcase
        end
      end
      CMD_LOAD: acc_next = ram_rdata;
      CMD_DIV: begin
        if (dcnt[5]) begin
          if (op == OP_MOD) acc_next = dneg_r ? 32'd0 - drem : drem;
          else acc_next = dneg_q ? 32'd0 - dq : dq;
        end else begin
          if (!dtrial[33]) begin
            drem_next = dtrial[31:0];
            dq_next   = {dq[30:0], 1'b1};
          end else begin
            drem_next = {drem[30:0], dq[31]};
            dq_next   = {dq[30:0], 1'b0};
          end
          dcnt_next = dcnt + 6'd1;
        end
      end
      CMD_CALL2: begin
        if (full) begin
          res_err_next = ERR_OVF;
        end else begin
          ram_we     = 1'b1;
          ram_wdata  = base;
          count_next = count + 1'b1;
          base_next  = 32'(count_next);
          if (opnd >= 32'(plen)) res_err_next = ERR_LABEL;
          else pc_next = opnd[16:0];
        end
      end
      CMD_RET_BASE: begin
        base_next = ram_rdata;
        if (count != '0) begin
          ram_re     = 1'b1;
          count_next = cnt_m1;
        end
      end
      CMD_RET_PC: begin
        pc_next = ram_rdata[16:0];
        if (ram_rdata >= 32'(plen)) halt_next = 1'b1;
      end
      CMD_FILL: begin
        ram_we     = 1'b1;
        count_next = count + 1'b1;
        fill_next  = fill_left - 1'b1;
      end
      CMD_EMIT: halt_next = halt_final;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 32'd0;
      sr        <= 32'd0;
      base      <= 32'd0;
      pc        <= 17'd0;
      halt_flag <= 1'b0;
      count     <= '0;
      plen      <= PLEN_RST;
      out_valid <= 1'b0;
    end else begin
      acc       <= acc_next;
      sr        <= sr_next;
      base      <= base_next;
      pc        <= pc_next;
      halt_flag <= halt_next;
      count     <= count_next;
      if (cfg_wr_en) begin
        plen <= (32'(cfg_wr_data) > PROGRAM_DEPTH) ? PLEN_MAX : cfg_wr_data;
      end
      out_valid <= (cmd == CMD_EMIT) || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LATCH) begin
      op     <= op_t'(mode);
      opnd   <= operand;
      inval  <= input_value;
      rvalid <= read_valid;
    end
    res_kind  <= res_kind_next;
    res_val   <= res_val_next;
    res_err   <= res_err_next;
    dq        <= dq_next;
    drem      <= drem_next;
    dmb       <= dmb_next;
    dcnt      <= dcnt_next;
    dneg_q    <= dneg_q_next;
    dneg_r    <= dneg_r_next;
    fill_left <= fill_next;
    if (cmd == CMD_EMIT) begin
      next_pc    <= pc;
      out_kind   <= res_kind;
      out_value  <= res_val;
      error_code <= res_err;
      halted     <= halt_final;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/svie_ctrl.sv */
`default_nettype none
module svie_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  svie_pkg::status_t  status,
  output svie_pkg::cmd_t     cmd
);
  import svie_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (status.pre_halt) state_next = S_DONE;
        else if (status.to_load) state_next = S_LOAD;
        else if (status.to_div) state_next = S_DIV;
        else if (status.to_call2) state_next = S_CALL2;
        else if (status.to_ret) state_next = S_RET_BASE;
        else if (status.to_fill) state_next = S_FILL;
        else state_next = S_DONE;
      end
      S_LOAD:     state_next = S_DONE;
      S_DIV:      if (status.div_last) state_next = S_DONE;
      S_CALL2:    state_next = S_DONE;
      S_RET_BASE: state_next = status.ret_more ? S_RET_PC : S_DONE;
      S_RET_PC:   state_next = S_DONE;
      S_FILL:     if (status.fill_last) state_next = S_DONE;
      S_DONE:     if (status.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = CMD_NONE;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE:     if (in_valid) cmd = CMD_LATCH;
      S_EXEC:     cmd = CMD_EXEC;
      S_LOAD:     cmd = CMD_LOAD;
      S_DIV:      cmd = CMD_DIV;
      S_CALL2:    cmd = CMD_CALL2;
      S_RET_BASE: cmd = CMD_RET_BASE;
      S_RET_PC:   cmd = CMD_RET_PC;
      S_FILL:     cmd = CMD_FILL;
      S_DONE:     if (status.out_free) cmd = CMD_EMIT;
      default:    cmd = CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/stack_vm_instruction_executor.sv */
// Stack machine instruction executor: one instruction per input item.
// Input channel (in_valid / in_stall): mode, operand, input_value, read_valid.
// Output channel (out_valid / out_stall): next_pc, out_kind, out_value,
//   error_code, halted -- exactly one result item per input item, in order.
// Config: cfg_wr_en / cfg_wr_data write program_length; write only when idle.
// Steps after the execute step, before the result is emitted:
//   simple ops, halted ops, most failing ops  none
//   LOAD, LOADR, POP, CALL             stack RAM read / second push
//   RETURN                             up to two dependent RAM reads
//   DIV, MOD                           radix-2 divider, 1 bit/cycle
//   ALLOC of n words (also on overflow)  one zero write per cycle per word added
// One item is in flight at a time: a new item is taken only once the last
// one is emitted. The result sits in an output register, so the next item is
// taken while a finished result is still stalled; that item then waits at its
// final step until the output register frees up.
// Reset (rst, synchronous): registers, stack count, frame base, pc and halt
// flag clear; program_length returns to its default. Stack RAM contents are
// not cleared; only entries below the stack count are ever read.
`default_nettype none
module stack_vm_instruction_executor #(
  parameter int STACK_DEPTH   = 1024,
  parameter int PROGRAM_DEPTH = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [16:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [5:0]  mode,
  input  wire logic [31:0] operand,
  input  wire logic [31:0] input_value,
  input  wire logic        read_valid,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      next_pc,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_value,
  output logic [2:0]       error_code,
  output logic             halted
);
  import svie_pkg::*;

  // controller <-> datapath
  cmd_t    cmd;
  status_t status;

  svie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: registers, stack RAM, divider, output register
  svie_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mode        (mode),
    .operand     (operand),
    .input_value (input_value),
    .read_valid  (read_valid),
    .cmd         (cmd),
    .status      (status),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .next_pc     (next_pc),
    .out_kind    (out_kind),
    .out_value   (out_value),
    .error_code  (error_code),
    .halted      (halted)
  );

endmodule
`default_nettype wire

/* hw/rtl/svie_checker.sv */
`default_nettype none
module svie_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [16:0] next_pc,
  input wire logic [1:0]  out_kind,
  input wire logic [31:0] out_value,
  input wire logic [2:0]  error_code,
  input wire logic        halted
);
  import svie_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc) && $stable(out_value))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted item while busy");

  // a write never carries an error
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_NONE |-> error_code == ERR_NONE)
    else $error("write with error");

  // no write means zero value
  a_no_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_NONE |-> out_value == 32'd0)
    else $error("value without write");

  // illegal opcode halts
  a_illegal: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_ILLEGAL |-> halted)
    else $error("illegal opcode did not halt");

endmodule

bind stack_vm_instruction_executor svie_checker u_svie_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .next_pc    (next_pc),
  .out_kind   (out_kind),
  .out_value  (out_value),
  .error_code (error_code),
  .halted     (halted)
);
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import svie_pkg::*;

  // One instruction item and the result item it produces.
  typedef struct {
    logic [5:0]  mode;
    logic [31:0] opnd;
    logic [31:0] inval;
    logic        rvalid;
  } instr_t;

  typedef struct {
    logic [16:0] pc;
    logic [1:0]  kind;
    logic [31:0] val;
    logic [2:0]  err;
    logic        hlt;
  } exec_result_t;

  // Directed row: instruction plus an optional hand-written result.
  typedef struct {
    instr_t       ins;
    bit           typed;
    exec_result_t res;
  } directed_row_t;

  localparam int STACK_WORDS = 1024;
  localparam logic [31:0] MAX_PLEN = 32'd65536;
  localparam logic [31:0] W_MIN = 32'h8000_0000;
  localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [5:0]  mode = '0;
  logic [31:0] operand = '0;
  logic [31:0] input_value = '0;
  logic        read_valid = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [16:0] next_pc;
  logic [1:0]  out_kind;
  logic [31:0] out_value;
  logic [2:0]  error_code;
  logic        halted;

  // program lengths of the random phases
  logic [16:0] plen_list [5] = '{17'd300, 17'd131071, 17'd4096, 17'd65535, 17'd70000};

  stack_vm_instruction_executor dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .operand(operand), .input_value(input_value), .read_valid(read_valid),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_pc(next_pc), .out_kind(out_kind), .out_value(out_value),
    .error_code(error_code), .halted(halted)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Machine model: our own copy of the executor state.
  // ---------------------------------------------------------------------------
  logic [31:0] vm_stk [STACK_WORDS];
  logic [31:0] vm_cnt = '0, vm_base = '0, vm_acc = '0, vm_sec = '0;
  logic [31:0] vm_pc = '0, vm_plen = MAX_PLEN;
  logic        vm_halt = 1'b0;

  exec_result_t pending_results[$];
  int unsigned  n_items = 0, n_checked = 0, n_mismatch = 0;
  int unsigned  err_seen[8];
  int unsigned  op_seen[64];

  function automatic logic [2:0] stack_push(logic [31:0] v);
    if (vm_cnt >= STACK_WORDS) return ERR_OVF;
    vm_stk[vm_cnt] = v;
    vm_cnt++;
    return ERR_NONE;
  endfunction

  function automatic logic [2:0] jump_to(logic [31:0] t);
    if (t >= vm_plen) return ERR_LABEL;
    vm_pc = t & 32'h1FFFF;
    return ERR_NONE;
  endfunction

  // Sign-magnitude divide so the most negative / -1 case wraps cleanly.
  function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b, bit want_rem);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    if (want_rem) begin
      q = ma % mb;
      return a[31] ? -q : q;
    end
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic exec_result_t execute_instr(instr_t it);
    exec_result_t r;
    logic [31:0]  a, room, n, v;
    bit           imm;
    r = '{default: '0};
    if (vm_halt || vm_pc >= vm_plen) begin
      vm_halt = 1'b1;
      r.pc = vm_pc[16:0];
      r.hlt = 1'b1;
      return r;
    end
    imm = it.mode inside {OP_SET, OP_JUMP, OP_JUMPF, OP_CALL, OP_ALLOC, OP_FREE};
    vm_pc = (vm_pc + (imm ? 32'd2 : 32'd1)) & 32'h1FFFF;
    case (it.mode)
      OP_NOP: ;
      OP_NEG: vm_acc = -vm_acc;
      OP_ADD: vm_acc = vm_acc + vm_sec;
      OP_SUB: vm_acc = vm_acc - vm_sec;
      OP_MUL: vm_acc = vm_acc * vm_sec;
      OP_DIV, OP_MOD: begin
        if (vm_sec == 0) r.err = ERR_DIV0;
        else vm_acc = trunc_div(vm_acc, vm_sec, it.mode == OP_MOD);
      end
      OP_EQUAL:   vm_acc = {31'd0, vm_acc == vm_sec};
      OP_NOTEQ:   vm_acc = {31'd0, vm_acc != vm_sec};
      OP_LESS:    vm_acc = {31'd0, $signed(vm_acc) <  $signed(vm_sec)};
      OP_LEQ:     vm_acc = {31'd0, $signed(vm_acc) <= $signed(vm_sec)};
      OP_GREATER: vm_acc = {31'd0, $signed(vm_acc) >  $signed(vm_sec)};
      OP_GEQ:     vm_acc = {31'd0, $signed(vm_acc) >= $signed(vm_sec)};
      OP_SET:     vm_acc = it.opnd;
      OP_LOAD, OP_LOADR: begin
        a = vm_acc + (it.mode == OP_LOADR ? vm_base : 32'd0);
        if (a < vm_cnt) vm_acc = vm_stk[a];
        else r.err = ERR_ADDR;
      end
      OP_SAVE, OP_SAVER: begin
        a = vm_sec + (it.mode == OP_SAVER ? vm_base : 32'd0);
        if (a < vm_cnt) vm_stk[a] = vm_acc;
        else r.err = ERR_ADDR;
      end
      OP_JUMP:  r.err = jump_to(it.opnd);
      OP_JUMPF: if (vm_acc == 0) r.err = jump_to(it.opnd);
      OP_PUSH:  r.err = stack_push(vm_acc);
      OP_POP: begin
        if (vm_cnt == 0) r.err = ERR_EMPTY;
        else begin
          vm_cnt--;
          vm_acc = vm_stk[vm_cnt];
        end
      end
      OP_SWAP: begin
        v = vm_acc;
        vm_acc = vm_sec;
        vm_sec = v;
      end
      OP_READ:    if (it.rvalid) vm_acc = it.inval; else r.err = ERR_READ;
      OP_WRITE:   begin r.kind = KIND_INT;  r.val = vm_acc; end
      OP_READCH:  vm_acc = it.inval;
      OP_WRITECH: begin r.kind = KIND_CHAR; r.val = vm_acc; end
      OP_HALT:    vm_halt = 1'b1;
      OP_CALL: begin
        r.err = stack_push(vm_pc);
        if (r.err == ERR_NONE) r.err = stack_push(vm_base);
        if (r.err == ERR_NONE) begin
          vm_base = vm_cnt;
          r.err = jump_to(it.opnd);
        end
      end
      OP_RETURN: begin
        if (vm_base[31]) begin
          vm_cnt = 0;
          r.err = ERR_EMPTY;
        end else begin
          if (vm_cnt > vm_base) vm_cnt = vm_base;
          if (vm_cnt > 0) begin
            vm_cnt--;
            vm_base = vm_stk[vm_cnt];
          end
          if (vm_cnt > 0) begin
            vm_cnt--;
            v = vm_stk[vm_cnt];
            vm_pc = v & 32'h1FFFF;
            if (v >= vm_plen) vm_halt = 1'b1;
          end
        end
      end
      OP_ALLOC: begin
        if (!it.opnd[31] && it.opnd != 0) begin
          room = STACK_WORDS - vm_cnt;
          n = (it.opnd > room) ? room : it.opnd;
          for (int i = 0; i < n; i++) vm_stk[vm_cnt + i] = '0;
          vm_cnt += n;
          if (it.opnd > room) r.err = ERR_OVF;
        end
      end
      OP_FREE: begin
        if (!it.opnd[31] && it.opnd != 0) begin
          if (it.opnd > vm_cnt) begin
            vm_cnt = 0;
            r.err = ERR_EMPTY;
          end else vm_cnt -= it.opnd;
        end
      end
      OP_TOPST: vm_acc = vm_cnt;
      default: begin
        r.err = ERR_ILLEGAL;
        vm_halt = 1'b1;
      end
    endcase
    if (vm_pc >= vm_plen) vm_halt = 1'b1;
    r.pc = vm_pc[16:0];
    r.hlt = vm_halt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall patterns; results are checked in order.
  // ---------------------------------------------------------------------------
  int unsigned stall_cycle = 0;
  logic [1:0]  stall_style = '0;

  always @(posedge clk) begin
    exec_result_t e;
    if (out_valid && !out_stall && !rst) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("[%0t] unexpected result item: pc=%0d err=%0d", $realtime, next_pc,
                   error_code);
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (next_pc !== e.pc || out_kind !== e.kind || out_value !== e.val ||
            error_code !== e.err || halted !== e.hlt) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"[%0t] mismatch: exp pc=%0d kind=%0d val=%h err=%0d hlt=%0b,",
                      " got pc=%0d kind=%0d val=%h err=%0d hlt=%0b"},
                     $realtime, e.pc, e.kind, e.val, e.err, e.hlt,
                     next_pc, out_kind, out_value, error_code, halted);
        end
      end
    end
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 256 == 0) stall_style <= 2'($urandom_range(0, 3));
    case (stall_style)
      2'd0: out_stall <= 1'b0;                          // stretch with no stalls
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);    // light
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);    // heavy
      default: out_stall <= ((stall_cycle / 24) % 2 == 1); // long on/off runs
    endcase
  end

  // ---------------------------------------------------------------------------
  // Item side: bursts of random length with random gaps between them.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  // Predicts, queues the expectation and drives one item until accepted.
  // Called just after a rising edge.
  task automatic issue(instr_t it, bit typed, exec_result_t hand);
    exec_result_t p;
    p = execute_instr(it);
    pending_results.push_back(typed ? hand : p);
    err_seen[p.err]++;
    op_seen[it.mode]++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid    <= 1'b1;
    mode        <= it.mode;
    operand     <= it.opnd;
    input_value <= it.inval;
    read_valid  <= it.rvalid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Idle-only register write.
  task automatic write_plen(logic [16:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vm_plen = ({15'd0, v} > MAX_PLEN) ? MAX_PLEN : {15'd0, v};
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return W_MIN;
      1: return W_MAX;
      2: return 32'hFFFF_FFFF;
      3, 4, 5, 6: return $urandom_range(0, vm_cnt + 3);  // likely stack address
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_target();
    case ($urandom_range(0, 19))
      0: return vm_plen + $urandom_range(0, 1000);
      1: return W_MIN | $urandom;
      2: return $urandom;
      default: return $urandom_range(0, vm_plen - 8);
    endcase
  endfunction

  op_t op_pool[$];

  function automatic instr_t random_instr();
    instr_t it;
    it.mode   = op_pool[$urandom_range(0, op_pool.size() - 1)];
    it.inval  = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : rand_word();
    it.rvalid = ($urandom_range(0, 4) != 0);
    it.opnd   = $urandom;
    case (it.mode)
      OP_SET: it.opnd = rand_word();
      OP_JUMP, OP_JUMPF, OP_CALL: it.opnd = rand_target();
      OP_ALLOC: case ($urandom_range(0, 19))
        0: it.opnd = '0;
        1: it.opnd = W_MIN | $urandom;
        2, 3: it.opnd = $urandom_range(100, 1100);
        default: it.opnd = $urandom_range(1, 6);
      endcase
      OP_FREE: case ($urandom_range(0, 9))
        0: it.opnd = '0;
        1: it.opnd = W_MIN | $urandom;
        2: it.opnd = $urandom_range(50, 2000);
        default: it.opnd = $urandom_range(1, 4);
      endcase
      default: ;
    endcase
    return it;
  endfunction

  // A random item that keeps the machine running: runs near the program end
  // are pulled back to 0, and a RETURN that would restore a bad counter is
  // rolled back and replaced.
  task automatic issue_random();
    instr_t it;
    logic [31:0] s_cnt, s_base, s_acc, s_sec, s_pc;
    exec_result_t p;
    it = random_instr();
    if (vm_pc + 8 >= vm_plen) it = '{OP_JUMP, 32'd0, $urandom, 1'b0};
    if (it.mode == OP_RETURN) begin
      s_cnt = vm_cnt; s_base = vm_base; s_acc = vm_acc; s_sec = vm_sec; s_pc = vm_pc;
      p = execute_instr(it);
      vm_cnt = s_cnt; vm_base = s_base; vm_acc = s_acc; vm_sec = s_sec; vm_pc = s_pc;
      vm_halt = 1'b0;
      if (p.hlt) it = '{OP_JUMP, 32'd0, $urandom, 1'b0};
    end
    issue(it, 1'b0, '{default: '0});
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows. Results are written out only for the first few, where the
  // state right after reset makes them obvious.
  // ---------------------------------------------------------------------------
  function automatic directed_row_t row(op_t op, logic [31:0] opnd = '0,
                                         logic [31:0] inval = '0, logic rv = 1'b0);
    directed_row_t d;
    d.ins = '{op, opnd, inval, rv};
    d.typed = 1'b0;
    d.res = '{default: '0};
    return d;
  endfunction

  function automatic directed_row_t row_exp(op_t op, logic [16:0] pc, logic [2:0] err);
    directed_row_t d;
    d = row(op);
    d.typed = 1'b1;
    d.res = '{pc, KIND_NONE, 32'd0, err, 1'b0};
    return d;
  endfunction

  directed_row_t directed[$];

  initial begin
    instr_t it;
    int     halt_cause;
    for (int i = 0; i < STACK_WORDS; i++) vm_stk[i] = '0;
    for (int i = 0; i <= 32; i++) begin
      // heavier weight on stack setup and addressing
      op_pool.push_back(op_t'(i));
      if (op_t'(i) inside {OP_SET, OP_PUSH, OP_LOAD, OP_LOADR, OP_SAVE, OP_SAVER,
                           OP_SWAP, OP_CALL, OP_RETURN})
        repeat (3) op_pool.push_back(op_t'(i));
    end
    op_pool = op_pool.find(x) with (x != OP_HALT);

    directed = '{
      row_exp(OP_NOP, 17'd1, ERR_NONE),
      row_exp(OP_POP, 17'd2, ERR_EMPTY),   // pop on empty stack
      row_exp(OP_LOAD, 17'd3, ERR_ADDR),   // nothing on the stack yet
      row_exp(OP_DIV, 17'd4, ERR_DIV0),
      row_exp(OP_MOD, 17'd5, ERR_DIV0),
      row(OP_SET, 32'hFFFF_FFFF), row(OP_SWAP), row(OP_SET, W_MIN),
      row(OP_DIV), row(OP_SET, W_MIN), row(OP_MOD),  // most negative by -1
      row(OP_SET, W_MAX), row(OP_NEG), row(OP_ADD), row(OP_SUB), row(OP_MUL),
      row(OP_EQUAL), row(OP_NOTEQ), row(OP_LESS), row(OP_LEQ), row(OP_GREATER), row(OP_GEQ),
      row(OP_READ, 0, 32'h1234_5678, 1'b0), row(OP_READ, 0, W_MIN, 1'b1),
      row(OP_WRITE), row(OP_READCH, 0, 32'hFFFF_FFFF), row(OP_WRITECH),
      row(OP_PUSH), row(OP_ALLOC, 32'd3), row(OP_TOPST), row(OP_SWAP),
      row(OP_SET, 32'd7), row(OP_SAVE), row(OP_SET, 32'd1), row(OP_LOADR),
      row(OP_SAVER), row(OP_CALL, 32'd200), row(OP_ALLOC, 32'd2), row(OP_RETURN),
      row(OP_JUMP, MAX_PLEN), row(OP_JUMPF, 32'd40), row(OP_FREE, 32'd1),
      row(OP_FREE, 32'd5000), row(OP_JUMP, 32'd0)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) issue(directed[i].ins, directed[i].typed, directed[i].res);

    // Random phases under several program lengths; each phase ends back at 0
    // so the next, possibly shorter, program still holds the counter.
    foreach (plen_list[p]) begin
      drain();
      write_plen(plen_list[p]);
      repeat (380) issue_random();
      if (p == 2) begin
        // let the pipe run dry mid-phase
        drain();
        repeat (10) issue_random();
      end
      issue('{OP_JUMP, 32'd0, 32'd0, 1'b0}, 1'b0, '{default: '0});
    end

    // Finale: only one halt can happen per run, so pick its cause.
    drain();
    halt_cause = $urandom_range(0, 2);
    if (halt_cause == 2) write_plen(17'd1);  // program runs off its end
    issue('{halt_cause == 0 ? 6'(OP_HALT) : 6'($urandom_range(33, 63)), $urandom,
            $urandom, 1'b1},
          1'b0, '{default: '0});
    issue('{6'(OP_HALT), 32'd0, 32'd0, 1'b0}, 1'b0, '{default: '0});
    issue('{6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, '{default: '0});
    repeat (6) begin
      it = random_instr();
      issue(it, 1'b0, '{default: '0});
    end
    drain();
    write_plen(17'd1);
    issue('{6'(OP_NOP), 32'd0, 32'd0, 1'b0}, 1'b0, '{default: '0});
    issue('{6'(OP_SET), 32'd5, 32'd0, 1'b0}, 1'b0, '{default: '0});

    drain();
    repeat (50) @(posedge clk);
    $display("Ran %0d instruction items, %0d results checked, %0d mismatches.",
             n_items, n_checked, n_mismatch);
    $display({"Error codes seen: div0 %0d, addr %0d, ovf %0d, empty %0d, label %0d,",
              " read %0d, illegal %0d; halted via cause %0d."},
             err_seen[1], err_seen[2], err_seen[3], err_seen[4], err_seen[5], err_seen[6],
             err_seen[7], halt_cause);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well above the slowest legal run.
  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
